// ===== sv/aes128_block_encrypt_unit_assert.svh =====
// Assertion macros for the AES-128 encrypt unit
`ifndef AES128_BLOCK_ENCRYPT_UNIT_ASSERT_SVH
`define AES128_BLOCK_ENCRYPT_UNIT_ASSERT_SVH
// implication checked on every clock, off during reset
`define AES_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);
// next-cycle implication
`define AES_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);
`endif

// ===== sv/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, S-box and round helper functions for the AES-128 unit.
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam int unsigned NumRounds = 10;

   typedef logic [127:0] aes_block_type;
   typedef logic [3:0]   aes_round_type;

   localparam logic [7:0] GfReduce = 8'h1B;

   // configuration register indexes
   localparam logic KeyHighIdx = 1'b0;
   localparam logic KeyLowIdx  = 1'b1;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] r;
      unique case (x)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? GfReduce : 8'h00);
   endfunction

   // byte i of the block sits at bits 127-8i .. 120-8i
   function automatic logic [7:0] get_byte(input aes_block_type b, input int i);
      return b[127 - 8*i -: 8];
   endfunction

   // SubBytes, ShiftRows and, unless last, MixColumns
   function automatic aes_block_type round_fn(input aes_block_type s, input logic last);
      aes_block_type t;
      aes_block_type m;
      logic [7:0] a0, a1, a2, a3, al;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(4*c + r) -: 8] = sbox(get_byte(s, 4*((c + r) % 4) + r));
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(t, 4*c);
         a1 = get_byte(t, 4*c + 1);
         a2 = get_byte(t, 4*c + 2);
         a3 = get_byte(t, 4*c + 3);
         al = a0 ^ a1 ^ a2 ^ a3;
         m[127 - 8*(4*c)     -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
         m[127 - 8*(4*c + 1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
         m[127 - 8*(4*c + 2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
         m[127 - 8*(4*c + 3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end
      return last ? t : m;
   endfunction

   // next round key from the previous one
   function automatic aes_block_type next_key(input aes_block_type k, input logic [7:0] rcon);
      logic [31:0] t;
      logic [31:0] w0, w1, w2, w3;
      t = {sbox(k[23:16]), sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])} ^ {rcon, 24'h0};
      w0 = k[127:96] ^ t;
      w1 = k[95:64] ^ w0;
      w2 = k[63:32] ^ w1;
      w3 = k[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic logic [7:0] rcon_of(input aes_round_type rnd);
      logic [7:0] r;
      unique case (rnd)
         4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
         4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
         4'd9: r = 8'h1B; 4'd10: r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/aes_key_sched.sv =====
// ----------------------------------------------------------------------------
// aes_key_sched
// Holds the key registers and the expanded round keys, one stage a round.
// ----------------------------------------------------------------------------
module aes_key_sched (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic                   csr_addr,
   input  logic [63:0]            csr_wdata,
   output aes_pkg::aes_block_type rkey_set [11]
);
   import aes_pkg::*;

   logic [63:0]   key_high_ff, key_low_ff;
   aes_block_type rk_ff [11];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_we) begin
         if (csr_addr == KeyHighIdx) key_high_ff <= csr_wdata;
         else                        key_low_ff  <= csr_wdata;
      end
   end

   // one expansion step per register; the round keys settle through the chain after a write
   always_ff @(posedge clock) begin
      rk_ff[0] <= {key_high_ff, key_low_ff};
      for (int r = 1; r < 11; r++) begin
         rk_ff[r] <= next_key(rk_ff[r-1], rcon_of(4'(r)));
      end
   end

   assign rkey_set = rk_ff;
endmodule

// ===== sv/aes_round_stage.sv =====
// ----------------------------------------------------------------------------
// aes_round_stage
// One cipher round with its round-key add, registered, stall aware.
// ----------------------------------------------------------------------------
module aes_round_stage #(
   parameter bit Last = 1'b0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  aes_pkg::aes_block_type in_state,
   input  aes_pkg::aes_block_type round_key,
   output logic                   out_valid,
   output aes_pkg::aes_block_type out_state
);
   import aes_pkg::*;

   logic          valid_ff;
   aes_block_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= round_fn(in_state, Last) ^ round_key;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;
endmodule

// ===== sv/aes128_block_encrypt_unit.sv =====
// An accepted item passes the key add register, then one register per round, before its result is valid.
// The unit takes one item per cycle; the whole pipeline holds when the output stalls.
// Round keys are re-expanded in an 11-stage register chain after each key write,
// so configuration must settle through that chain before the next item enters.
// Reset clears the key to zero and empties the pipeline.
// ----------------------------------------------------------------------------
// aes128_block_encrypt_unit
// Pipelined AES-128 encryption, one round per register stage.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // plain_high, plain_low
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // cipher_high, cipher_low
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [63:0]  csr_wdata
);
   import aes_pkg::*;
   `include "aes128_block_encrypt_unit_assert.svh"

   aes_block_type rkey_set [11];
   logic          advance;
   logic          v     [11];
   aes_block_type s     [11];
   aes_block_type plain;

   aes_key_sched u_keys (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_addr(csr_addr),
      .csr_wdata(csr_wdata), .rkey_set(rkey_set)
   );

   // the block is stored with byte 0 in the top bits
   assign plain = {req_tdata[63:0], req_tdata[127:64]};

   assign advance    = !v[10] || rsp_tready;
   assign req_tready = advance;

   logic          v0_ff;
   aes_block_type s0_ff;
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (advance) v0_ff <= req_tvalid;
   end
   always_ff @(posedge clock) begin
      if (advance) s0_ff <= plain ^ rkey_set[0];
   end
   assign v[0] = v0_ff;
   assign s[0] = s0_ff;

   for (genvar r = 1; r < 11; r++) begin : g_round
      aes_round_stage #(.Last(r == 10)) u_round (
         .clock(clock), .reset(reset), .advance(advance),
         .in_valid(v[r-1]), .in_state(s[r-1]), .round_key(rkey_set[r]),
         .out_valid(v[r]), .out_state(s[r])
      );
   end

   assign rsp_tvalid = v[10];
   assign rsp_tdata  = {s[10][63:0], s[10][127:64]};

   `AES_ASSERT_IMPL(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready, "ready low with empty output")
   `AES_ASSERT_NEXT(a_hold_on_stall, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed under stall")
   `AES_ASSERT_NEXT(a_entry_tracks, clock, reset, req_tvalid && req_tready, v[0], "accepted item lost at entry")
endmodule
